// File: rtl/mbsp_pkg.sv
// Package for the MIDI byte stream parser: result record, data count classes
// and the status byte decode table. No dependencies.
package mbsp_pkg;

  // End of exclusive status byte.
  localparam logic [7:0] STATUS_EOX = 8'hF7;

  // How many data bytes a status byte calls for.
  typedef enum logic [1:0] {
    COUNT_ZERO  = 2'd0,
    COUNT_ONE   = 2'd1,
    COUNT_TWO   = 2'd2,
    COUNT_SYSEX = 2'd3
  } count_class_e;

  // One result item as it leaves the parser.
  typedef struct packed {
    logic [3:0] slot;
    logic [4:0] position;
    logic [7:0] byte_value;
    logic       status_restated;
    logic       message_done;
    logic [5:0] message_length;
    logic       overflow;
  } result_t;

  // Standard MIDI data count table; unknown system codes are treated as sysex.
  function automatic count_class_e count_class(input logic [7:0] status);
    count_class_e cls;
    cls = COUNT_TWO;
    case (status[7:4])
      4'hC, 4'hD: cls = COUNT_ONE;
      4'hF: begin
        case (status[3:0])
          4'h1, 4'h3: cls = COUNT_ONE;
          4'h2: cls = COUNT_TWO;
          4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: cls = COUNT_ZERO;
          default: cls = COUNT_SYSEX;
        endcase
      end
      default: cls = COUNT_TWO;
    endcase
    return cls;
  endfunction

endpackage

// File: rtl/midi_byte_stream_parser_core.sv
// Top level of the MIDI byte stream parser: parser state, output register
// and handshakes. Depends on mbsp_pkg and mbsp_step.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one raw MIDI byte per item.
//   Output channel: out_valid_o / out_stall_i carry one result item per
//   input item: ring slot, position, stored byte, running status flag,
//   message completion with its length, and the end of exclusive overflow.
//   An item moves on a rising edge where valid is high and stall is low.
//   Latency: the result of a byte is shown on the cycle after it is taken.
//   Throughput: one byte per cycle; the parser state is updated in the same
//   cycle the byte is accepted, so each byte sees the state left by the
//   previous one.
//   Stall: the output register holds its item while out_stall_i is high, and
//   in_stall_o is raised only when that register is full and stalled, so a
//   new byte is taken in the cycle the waiting result leaves.
//   Reset: rst_ni clears the working status, data count, position, write
//   slot and the output valid bit; the block is ready at once.
module midi_byte_stream_parser_core #(
  parameter int BUFFER_SLOTS      = 16,
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] slot_o,
  output logic [4:0] position_o,
  output logic [7:0] byte_value_o,
  output logic       status_restated_o,
  output logic       message_done_o,
  output logic [5:0] message_length_o,
  output logic       overflow_o
);

  localparam int SW = $clog2(BUFFER_SLOTS);
  localparam int PW = $clog2(MAX_MESSAGE_BYTES);

  logic [7:0]         working_status_q, working_status_d;
  logic [PW-1:0]      expected_count_q, expected_count_d;
  logic [PW-1:0]      data_position_q, data_position_d;
  logic [SW-1:0]      write_slot_q, write_slot_d;
  logic               out_valid_q, out_valid_d;
  mbsp_pkg::result_t  result_q, result_d;
  logic               in_accept;

  // Take a byte whenever the output register is free or draining.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  mbsp_step #(
    .BUFFER_SLOTS      (BUFFER_SLOTS),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_step (
    .in_byte_i        (in_byte_i),
    .working_status_i (working_status_q),
    .expected_count_i (expected_count_q),
    .data_position_i  (data_position_q),
    .write_slot_i     (write_slot_q),
    .working_status_o (working_status_d),
    .expected_count_o (expected_count_d),
    .data_position_o  (data_position_d),
    .write_slot_o     (write_slot_d),
    .result_o         (result_d)
  );

  // Output valid follows accepts and drains.
  assign out_valid_d = in_accept || (out_valid_q && out_stall_i);

  // Parser state, updated on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      working_status_q <= '0;
      expected_count_q <= '0;
      data_position_q  <= '0;
      write_slot_q     <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        working_status_q <= working_status_d;
        expected_count_q <= expected_count_d;
        data_position_q  <= data_position_d;
        write_slot_q     <= write_slot_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign slot_o            = result_q.slot;
  assign position_o        = result_q.position;
  assign byte_value_o      = result_q.byte_value;
  assign status_restated_o = result_q.status_restated;
  assign message_done_o    = result_q.message_done;
  assign message_length_o  = result_q.message_length;
  assign overflow_o        = result_q.overflow;

  // The write slot stays inside the ring.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(write_slot_q) < BUFFER_SLOTS)
    else $error("write slot outside the ring");

  // An overflowed end of exclusive never completes a message.
  a_ovf_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !message_done_o && position_o == 5'd0)
    else $error("overflow result with completion or position");

  // Running status always writes the first data byte at position one.
  a_restated_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_restated_o |-> position_o == 5'd1 && !byte_value_o[7])
    else $error("restated status with wrong position or a status byte");

  // A waiting result blocks new items, so none is overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !in_accept)
    else $error("item accepted while the output register is stalled");

endmodule

// File: rtl/mbsp_step.sv
// Per-byte decode of the MIDI parser: next parser state and the result item.
// Depends on mbsp_pkg for the count table and the result record.
module mbsp_step #(
  parameter int BUFFER_SLOTS      = 16,
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic [7:0]                             in_byte_i,
  input  logic [7:0]                             working_status_i,
  input  logic [$clog2(MAX_MESSAGE_BYTES)-1:0]   expected_count_i,
  input  logic [$clog2(MAX_MESSAGE_BYTES)-1:0]   data_position_i,
  input  logic [$clog2(BUFFER_SLOTS)-1:0]        write_slot_i,
  output logic [7:0]                             working_status_o,
  output logic [$clog2(MAX_MESSAGE_BYTES)-1:0]   expected_count_o,
  output logic [$clog2(MAX_MESSAGE_BYTES)-1:0]   data_position_o,
  output logic [$clog2(BUFFER_SLOTS)-1:0]        write_slot_o,
  output mbsp_pkg::result_t                      result_o
);

  localparam int SW = $clog2(BUFFER_SLOTS);
  localparam int PW = $clog2(MAX_MESSAGE_BYTES);
  localparam int LW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(BUFFER_SLOTS - 1);
  localparam logic [PW-1:0] LAST_POS  = PW'(MAX_MESSAGE_BYTES - 1);

  logic [SW-1:0]          slot_next;
  logic [SW-1:0]          slot_prev;
  logic [PW:0]            data_idx;
  logic [PW-1:0]          count_new;
  mbsp_pkg::count_class_e cls;
  logic [SW-1:0]          slot_w;
  logic [PW-1:0]          pos_w;
  logic [LW-1:0]          len_w;
  logic                   restated_w;
  logic                   done_w;
  logic                   ovf_w;

  // Ring neighbors of the write slot.
  assign slot_next = (write_slot_i == LAST_SLOT) ? '0 : write_slot_i + 1'b1;
  assign slot_prev = (write_slot_i == '0) ? LAST_SLOT : write_slot_i - 1'b1;
  assign data_idx  = {1'b0, data_position_i} + 1'b1;

  // Data count for a fresh status byte.
  always_comb begin
    cls = mbsp_pkg::count_class(in_byte_i);
    case (cls)
      mbsp_pkg::COUNT_ZERO: count_new = '0;
      mbsp_pkg::COUNT_ONE:  count_new = PW'(1);
      mbsp_pkg::COUNT_TWO:  count_new = PW'(2);
      default:              count_new = LAST_POS;
    endcase
  end

  // Next state and result fields.
  always_comb begin
    working_status_o = working_status_i;
    expected_count_o = expected_count_i;
    data_position_o  = data_position_i;
    write_slot_o     = write_slot_i;
    slot_w           = write_slot_i;
    pos_w            = '0;
    len_w            = '0;
    restated_w       = 1'b0;
    done_w           = 1'b0;
    ovf_w            = 1'b0;
    if (in_byte_i[7]) begin
      working_status_o = in_byte_i;
      if (in_byte_i == mbsp_pkg::STATUS_EOX) begin
        // End of exclusive closes the slot opened last, if there is room.
        expected_count_o = '0;
        slot_w           = slot_prev;
        if (data_position_i != LAST_POS) begin
          data_position_o = data_idx[PW-1:0];
          pos_w           = data_idx[PW-1:0];
          done_w          = 1'b1;
          len_w           = LW'(data_idx) + 1'b1;
        end else begin
          ovf_w = 1'b1;
        end
      end else begin
        // Any other status opens the next slot.
        expected_count_o = count_new;
        data_position_o  = '0;
        write_slot_o     = slot_next;
        if (count_new == '0) begin
          done_w = 1'b1;
          len_w  = LW'(1);
        end
      end
    end else if (data_idx <= {1'b0, expected_count_i}) begin
      // Data byte within the open message.
      slot_w          = slot_prev;
      data_position_o = data_idx[PW-1:0];
      pos_w           = data_idx[PW-1:0];
      if (data_idx == {1'b0, expected_count_i}) begin
        done_w = 1'b1;
        len_w  = LW'(expected_count_i) + 1'b1;
      end
    end else begin
      // Running status: a new slot with the saved status restated.
      write_slot_o    = slot_next;
      data_position_o = PW'(1);
      pos_w           = PW'(1);
      restated_w      = 1'b1;
      if (expected_count_i == PW'(1)) begin
        done_w = 1'b1;
        len_w  = LW'(2);
      end
    end
  end

  assign result_o.slot            = 4'(slot_w);
  assign result_o.position        = 5'(pos_w);
  assign result_o.byte_value      = in_byte_i;
  assign result_o.status_restated = restated_w;
  assign result_o.message_done    = done_w;
  assign result_o.message_length  = 6'(len_w);
  assign result_o.overflow        = ovf_w;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for midi_byte_stream_parser_core: drives MIDI bytes
// with random idling on both channels and checks every result item against
// its own parser prediction. Depends on mbsp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS       = 16;
  localparam int MSG_BYTES   = 32;
  localparam int CYCLE_LIMIT = 200000;

  // Channel voice status nibbles.
  localparam logic [3:0] NOTE_OFF      = 4'h8;
  localparam logic [3:0] NOTE_ON       = 4'h9;
  localparam logic [3:0] PROGRAM       = 4'hC;
  localparam logic [3:0] CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] PITCH_BEND    = 4'hE;

  // System status bytes.
  localparam logic [7:0] SYS_EXCLUSIVE = 8'hF0;
  localparam logic [7:0] SYS_TIME_CODE = 8'hF1;
  localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
  localparam logic [7:0] SYS_UNDEF_F4  = 8'hF4;
  localparam logic [7:0] SYS_UNDEF_F5  = 8'hF5;
  localparam logic [7:0] SYS_TUNE_REQ  = 8'hF6;
  localparam logic [7:0] RT_CLOCK      = 8'hF8;
  localparam logic [7:0] RT_UNDEF_F9   = 8'hF9;
  localparam logic [7:0] RT_START      = 8'hFA;
  localparam logic [7:0] RT_CONTINUE   = 8'hFB;
  localparam logic [7:0] RT_STOP       = 8'hFC;
  localparam logic [7:0] RT_UNDEF_FD   = 8'hFD;
  localparam logic [7:0] RT_SENSING    = 8'hFE;
  localparam logic [7:0] RT_RESET      = 8'hFF;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] slot_o;
  logic [4:0] position_o;
  logic [7:0] byte_value_o;
  logic       status_restated_o;
  logic       message_done_o;
  logic [5:0] message_length_o;
  logic       overflow_o;

  // Parser state as predicted; the saved status itself never shows in a result.
  int status_data_count = 0;
  int last_position     = 0;
  int next_free_slot    = 0;

  mbsp_pkg::result_t pending_results[$];

  bit idle_on    = 1'b1;
  int stall_left = 0;
  int bytes_sent = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int messages_completed = 0;
  int restates_seen = 0;
  int overflows_seen = 0;

  midi_byte_stream_parser_core #(
    .BUFFER_SLOTS      (SLOTS),
    .MAX_MESSAGE_BYTES (MSG_BYTES)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .slot_o            (slot_o),
    .position_o        (position_o),
    .byte_value_o      (byte_value_o),
    .status_restated_o (status_restated_o),
    .message_done_o    (message_done_o),
    .message_length_o  (message_length_o),
    .overflow_o        (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Data bytes that a status byte calls for; unknown system codes act as sysex.
  function automatic int data_bytes_for(input logic [7:0] status);
    if (status[7:4] == PROGRAM || status[7:4] == CHAN_PRESSURE) return 1;
    if (status[7:4] != 4'hF) return 2;
    case (status)
      SYS_TIME_CODE, SYS_SONG_SEL: return 1;
      SYS_SONG_POS: return 2;
      SYS_TUNE_REQ, RT_CLOCK, RT_START, RT_CONTINUE, RT_STOP, RT_SENSING, RT_RESET:
        return 0;
      default: return MSG_BYTES - 1;
    endcase
  endfunction

  // Advance the predicted parser state by one byte and queue its result.
  task automatic predict_parse(input logic [7:0] value);
    mbsp_pkg::result_t r;
    int prev_slot;
    r = '0;
    r.byte_value = value;
    prev_slot = (next_free_slot == 0) ? SLOTS - 1 : next_free_slot - 1;
    if (value[7]) begin
      status_data_count = 0;
      if (value == mbsp_pkg::STATUS_EOX) begin
        // End of exclusive lands after the last byte of the slot opened last.
        r.slot = 4'(prev_slot);
        if (last_position + 1 < MSG_BYTES) begin
          last_position++;
          r.position       = 5'(last_position);
          r.message_done   = 1'b1;
          r.message_length = 6'(last_position + 1);
        end else begin
          r.overflow = 1'b1;
        end
      end else begin
        status_data_count = data_bytes_for(value);
        r.slot = 4'(next_free_slot);
        last_position = 0;
        next_free_slot = (next_free_slot + 1) % SLOTS;
        if (status_data_count == 0) begin
          r.message_done   = 1'b1;
          r.message_length = 6'd1;
        end
      end
    end else if (last_position + 1 <= status_data_count) begin
      last_position++;
      r.slot     = 4'(prev_slot);
      r.position = 5'(last_position);
      if (last_position == status_data_count) begin
        r.message_done   = 1'b1;
        r.message_length = 6'(status_data_count + 1);
      end
    end else begin
      // Running status: a new slot with the saved status restated.
      r.slot = 4'(next_free_slot);
      next_free_slot = (next_free_slot + 1) % SLOTS;
      last_position = 1;
      r.position = 5'd1;
      r.status_restated = 1'b1;
      if (status_data_count == 1) begin
        r.message_done   = 1'b1;
        r.message_length = 6'd2;
      end
    end
    if (r.message_done) messages_completed++;
    if (r.status_restated) restates_seen++;
    if (r.overflow) overflows_seen++;
    pending_results.push_back(r);
  endtask

  // Send one byte, with an occasional idle burst first; valid stays high after.
  task automatic send_byte(input logic [7:0] value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_parse(value);
    bytes_sent++;
  endtask

  // Hold the input off until every queued result has been seen.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_data();
    return 8'($urandom_range(0, 127));
  endfunction

  // Data bytes before any status restate the reset status of zero.
  task automatic test_data_before_status();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  // One of each count class, running status, realtime and end of exclusive.
  task automatic test_message_classes();
    send_byte({NOTE_ON, 4'h0});
    send_byte(8'h3C);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte({PROGRAM, 4'hF});
    send_byte(8'h7F);
    send_byte(SYS_SONG_POS);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(SYS_TIME_CODE);
    send_byte(8'h10);
    send_byte(RT_CLOCK);
    send_byte(8'h05);
    send_byte(RT_RESET);
    send_byte(RT_UNDEF_F9);
    send_byte(8'h01);
    send_byte(mbsp_pkg::STATUS_EOX);
    send_byte(mbsp_pkg::STATUS_EOX);
    send_byte({NOTE_OFF, 4'h3});
    send_byte(mbsp_pkg::STATUS_EOX);
    send_byte({PITCH_BEND, 4'h7});
  endtask

  // Fill a sysex slot to its last byte, then push end of exclusive past it.
  task automatic test_sysex_capacity();
    send_byte(SYS_EXCLUSIVE);
    repeat (MSG_BYTES - 2) send_byte(random_data());
    send_byte(mbsp_pkg::STATUS_EOX);
    send_byte(mbsp_pkg::STATUS_EOX);
    send_byte(8'h00);
  endtask

  // One random message: mostly well formed, sometimes cut short or noise.
  task automatic send_random_message();
    logic [7:0] status;
    int kind, count, groups, pick;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
      count = data_bytes_for(status);
      groups = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
      if ($urandom_range(0, 9) == 0) count = count - 1;
      send_byte(status);
      repeat (groups) repeat (count) send_byte(random_data());
    end else if (kind < 60) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: status = SYS_TIME_CODE;
        1: status = SYS_SONG_POS;
        2: status = SYS_SONG_SEL;
        default: status = SYS_TUNE_REQ;
      endcase
      send_byte(status);
      repeat (data_bytes_for(status)) send_byte(random_data());
    end else if (kind < 72) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: status = RT_CLOCK;
        1: status = RT_START;
        2: status = RT_CONTINUE;
        3: status = RT_STOP;
        4: status = RT_SENSING;
        default: status = RT_RESET;
      endcase
      send_byte(status);
    end else if (kind < 88) begin
      pick = $urandom_range(0, 4);
      case (pick)
        0: status = SYS_EXCLUSIVE;
        1: status = SYS_UNDEF_F4;
        2: status = SYS_UNDEF_F5;
        3: status = RT_UNDEF_F9;
        default: status = RT_UNDEF_FD;
      endcase
      // Mostly short dumps; now and then one near, at or past the slot capacity.
      pick = $urandom_range(0, 19);
      if (pick == 0) count = $urandom_range(MSG_BYTES - 3, MSG_BYTES + 1);
      else if (pick < 3) count = $urandom_range(9, MSG_BYTES - 3);
      else count = $urandom_range(0, 8);
      send_byte(status);
      repeat (count) send_byte(random_data());
      if ($urandom_range(0, 9) != 0) send_byte(mbsp_pkg::STATUS_EOX);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Random stream with idling, then a final stretch at full rate.
  task automatic test_random_stream();
    int target;
    target = bytes_sent + 600;
    while (bytes_sent < target) send_random_message();
    wait_for_results();
    idle_on = 1'b0;
    target = bytes_sent + 100;
    while (bytes_sent < target) send_random_message();
  endtask

  // Random stall bursts on the result side.
  always @(posedge clk_i) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 7);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result item with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    mbsp_pkg::result_t got, want;
    string bad;
    if (out_valid_o && !out_stall_i) begin
      got = {slot_o, position_o, byte_value_o, status_restated_o, message_done_o,
             message_length_o, overflow_o};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Result with no byte pending: slot %0d pos %0d byte %02h",
                   got.slot, got.position, got.byte_value);
      end else begin
        want = pending_results.pop_front();
        bad = "";
        if (got.slot !== want.slot) bad = {bad, " slot"};
        if (got.position !== want.position) bad = {bad, " position"};
        if (got.byte_value !== want.byte_value) bad = {bad, " byte_value"};
        if (got.status_restated !== want.status_restated) bad = {bad, " status_restated"};
        if (got.message_done !== want.message_done) bad = {bad, " message_done"};
        if (got.message_length !== want.message_length) bad = {bad, " message_length"};
        if (got.overflow !== want.overflow) bad = {bad, " overflow"};
        if (bad != "") begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch in%s:", bad);
            $display("  expected slot %0d pos %0d byte %02h rs %0b done %0b len %0d ovf %0b",
                     want.slot, want.position, want.byte_value, want.status_restated,
                     want.message_done, want.message_length, want.overflow);
            $display("  got      slot %0d pos %0d byte %02h rs %0b done %0b len %0d ovf %0b",
                     got.slot, got.position, got.byte_value, got.status_restated,
                     got.message_done, got.message_length, got.overflow);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_data_before_status();
    test_message_classes();
    wait_for_results();
    test_sysex_capacity();
    wait_for_results();
    test_random_stream();
    wait_for_results();
    repeat (10) @(posedge clk_i);
    $display("Parsed %0d bytes: %0d messages completed, %0d running status restates,",
             bytes_sent, messages_completed, restates_seen);
    $display("%0d end of exclusive overflows, %0d failures.", overflows_seen, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: midi_byte_stream_parser_core.f
rtl/mbsp_pkg.sv
rtl/mbsp_step.sv
rtl/midi_byte_stream_parser_core.sv
tb/sv/tb_top.sv
